// ===== design/bse_pkg.sv =====
package bse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_res;
    logic                     overflow;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_SORT  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

endpackage

// ===== design/bse_ram.sv =====
module bse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/bubble_sort_engine.sv =====
// batch sorter: values load at one transfer per cycle while busy is low
// after the last value: a setup state, then one bubble pass of m entries plus a flush for
// each m = n..2 (store port: one read and one write a cycle), then n results, one a cycle
// the last result shows in the same cycle that busy falls; the receiver cannot stall
// reset (rst_n low, synchronous): empty store, no overflow, idle and ready
module bubble_sort_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bse_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output bse_pkg::out_item_t  out_item
);

  import bse_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // control state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;      // values held in the batch
  logic            ovf_r, ovf_nxt;      // a value was dropped this batch
  logic [CW-1:0]   m_r, m_nxt;          // length of the current bubble pass
  logic [AW-1:0]   idx_r, idx_nxt;      // entry whose read data arrives this cycle
  logic            out_strobe_r, out_strobe_nxt;

  // datapath
  logic [DATA_W-1:0] carry_r, carry_nxt; // running maximum of the pass
  out_item_t         out_item_r, out_item_nxt;

  // store port
  logic              we;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;
  logic [AW-1:0]     ra;
  logic [DATA_W-1:0] rd;

  logic              accept;
  logic              has_room;
  logic [CW-1:0]     n_batch;
  logic [CW-1:0]     m_last;
  logic [CW-1:0]     n_last;
  logic              idx_at_m_last;
  logic              idx_at_n_last;
  logic              carry_bigger;

  bse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (wa),
    .wr_data (wd),
    .rd_addr (ra),
    .rd_data (rd)
  );

  assign busy     = (state_r != ST_LOAD);
  assign accept   = start && !busy;
  assign has_room = (cnt_r < CW'(CAPACITY));
  // size of the batch once this value is in
  assign n_batch  = has_room ? CW'(cnt_r + 1'b1) : cnt_r;

  assign m_last        = CW'(m_r - 1'b1);
  assign n_last        = CW'(cnt_r - 1'b1);
  assign idx_at_m_last = (CW'(idx_r) == m_last);
  assign idx_at_n_last = (CW'(idx_r) == n_last);

  // signed compare; the larger value moves on toward the end
  assign carry_bigger = ($signed(carry_r) > $signed(rd));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    m_nxt          = m_r;
    idx_nxt        = idx_r;
    carry_nxt      = carry_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    we             = 1'b0;
    wa             = cnt_r[AW-1:0];
    wd             = in_item.value;
    ra             = AW'(idx_r + 1'b1);

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (has_room) begin
            we      = 1'b1;
            cnt_nxt = CW'(cnt_r + 1'b1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_item.last) begin
            m_nxt     = n_batch;
            state_nxt = ST_PREP;
          end
        end
      end

      // issue the read of entry 0 for the first pass or for the emit run
      ST_PREP: begin
        ra      = '0;
        idx_nxt = '0;
        if (m_r < CW'(2)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SORT;
        end
      end

      // one entry per cycle: the smaller of carry and the new entry drops back one slot
      ST_SORT: begin
        if (idx_r == '0) begin
          carry_nxt = rd;
        end else begin
          we = 1'b1;
          wa = AW'(idx_r - 1'b1);
          if (carry_bigger) begin
            wd = rd;
          end else begin
            wd        = carry_r;
            carry_nxt = rd;
          end
        end
        if (idx_at_m_last) begin
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = AW'(idx_r + 1'b1);
        end
      end

      // park the pass maximum in the last slot and start the next pass, or the emit run after the last pass
      ST_FLUSH: begin
        we      = 1'b1;
        wa      = m_last[AW-1:0];
        wd      = carry_r;
        ra      = '0;
        idx_nxt = '0;
        m_nxt   = m_last;
        if (m_last < CW'(2)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SORT;
        end
      end

      // read out in order, one result transfer per cycle
      ST_EMIT: begin
        out_strobe_nxt            = 1'b1;
        out_item_nxt.sorted_value = rd;
        out_item_nxt.last_res     = idx_at_n_last;
        out_item_nxt.overflow     = ovf_r;
        idx_nxt                   = AW'(idx_r + 1'b1);
        if (idx_at_n_last) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      m_r          <= '0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      m_r          <= m_nxt;
      idx_r        <= idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    carry_r    <= carry_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ===== dv/bse_checker.sv =====
// watches both channels of the sorter, predicts each batch and compares results
module bse_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  bse_pkg::in_item_t   in_item,
  input  logic                out_strobe,
  input  bse_pkg::out_item_t  out_item,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;

  logic signed [DATA_W-1:0] batch_vals [CAPACITY];
  int unsigned              batch_len;
  logic                     batch_dropped;
  out_item_t                sorted_due_q [$];

  always @(posedge clk) begin : watch
    out_item_t                want;
    logic signed [DATA_W-1:0] key;
    int                       j;
    if (!rst_n) begin
      batch_len     = 0;
      batch_dropped = 1'b0;
    end else begin
      // result side: one transfer per strobe, no back-pressure
      if (out_strobe) begin
        if (sorted_due_q.size() == 0) begin
          $error("unexpected result: sorted_value %0d last_res %0b overflow %0b",
                 out_item.sorted_value, out_item.last_res, out_item.overflow);
          fail_count++;
        end else begin
          want = sorted_due_q.pop_front();
          if (out_item.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d",
                   want.sorted_value, out_item.sorted_value);
            fail_count++;
          end
          if (out_item.last_res !== want.last_res) begin
            $error("last_res: expected %0b, got %0b", want.last_res, out_item.last_res);
            fail_count++;
          end
          if (out_item.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_item.overflow);
            fail_count++;
          end
        end
      end

      // input side: collect, drop when full, sort on the last value
      if (start && !busy) begin
        if (batch_len < CAPACITY) begin
          batch_vals[batch_len] = in_item.value;
          batch_len++;
        end else begin
          batch_dropped = 1'b1;
        end
        if (in_item.last) begin
          for (int i = 1; i < int'(batch_len); i++) begin
            key = batch_vals[i];
            j   = i - 1;
            while (j >= 0 && batch_vals[j] > key) begin
              batch_vals[j+1] = batch_vals[j];
              j--;
            end
            batch_vals[j+1] = key;
          end
          for (int k = 0; k < int'(batch_len); k++) begin
            want.sorted_value = batch_vals[k];
            want.last_res     = (k == int'(batch_len) - 1);
            want.overflow     = batch_dropped;
            sorted_due_q      = {sorted_due_q, want};
          end
          batch_len     = 0;
          batch_dropped = 1'b0;
        end
      end
    end
    pending = sorted_due_q.size();
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int          NUM_ITEMS   = 430;
  localparam int          CYCLE_LIMIT = 300000;
  // no idling at all while this window of transfers goes in
  localparam int          QUIET_LO    = 150;
  localparam int          QUIET_HI    = 260;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_item;

  int fail_count;
  int pending;
  int sent = 0;

  always #6 clk = ~clk;

  bubble_sort_engine #(
    .CAPACITY (CAPACITY)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // checker sits beside the block and sees the same pins
  bse_checker #(
    .CAPACITY (CAPACITY)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // present one value from a falling edge until a transfer happens;
  // start drops at random on any cycle, busy or not, outside the quiet window
  task automatic push_value(input logic signed [DATA_W-1:0] v, input logic lst);
    logic done;
    in_item <= '{value: v, last: lst};
    do begin
      start <= (sent >= QUIET_LO && sent < QUIET_HI) || ($urandom_range(99) >= 31);
      @(posedge clk);
      done = start && !busy;
      @(negedge clk);
    end while (!done);
    sent++;
  endtask

  // watchdog: covers the slowest legal run many times over
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic signed [DATA_W-1:0] v;
    int                       len;
    int                       mode;
    int                       pick;

    // synchronous reset: rst_n starts low and is released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-value batches at both ends of the range
    push_value(32'sh7FFFFFFF, 1'b1);
    push_value(32'sh80000000, 1'b1);

    // equal values must come out side by side
    push_value(5, 1'b0);
    push_value(-5, 1'b0);
    push_value(5, 1'b1);

    // store fills up, then the last value itself finds no room and is dropped
    for (int i = 0; i <= int'(CAPACITY); i++) begin
      v = (i % 3 == 0) ? 32'sh80000000 : (int'(CAPACITY) - i) * 1000;
      push_value(v, i == int'(CAPACITY));
    end

    // random batches: mostly legal sizes, some full, some overflowing
    while (sent < NUM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10)      len = 1;
      else if (pick < 70) len = $urandom_range(CAPACITY, 2);
      else if (pick < 85) len = CAPACITY;
      else                len = $urandom_range(CAPACITY + 6, CAPACITY + 1);
      mode = $urandom_range(3);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: v = $urandom();
          // narrow range forces many duplicates
          1: v = int'($urandom_range(8)) - 4;
          2: begin
            case ($urandom_range(3))
              0: v = 32'sh7FFFFFFF;
              1: v = 32'sh80000000;
              2: v = 0;
              default: v = -1;
            endcase
          end
          default: v = int'($urandom_range(1000)) - 500;
        endcase
        push_value(v, k == len - 1);
      end
    end
    start <= 1'b0;

    // drain: every predicted result must have come out
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
